// File: src/frdt_pkg.sv
// Shared types, codes and sizes of the flood relay duplicate table.
`default_nettype none
package frdt_pkg;

  // Table size and derived widths
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int TIME_W   = 32;
  localparam int ID_W     = 8;
  localparam int WORD_W   = 32;
  localparam int TYPE_W   = 8;
  localparam int HOP_W    = 8;
  localparam int SLEN_W   = 8;
  localparam int DRAW_W   = 7;
  localparam int KEEP_W   = 16;
  localparam int RLEN_W   = 9;
  localparam int MEMBER_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Packet type codes
  localparam logic [TYPE_W-1:0] TYPE_HEARTBEAT  = 8'd7;
  localparam logic [TYPE_W-1:0] TYPE_UNI_STRING = 8'd8;
  localparam logic [TYPE_W-1:0] TYPE_UNI_NUMBER = 8'd9;
  localparam logic [TYPE_W-1:0] TYPE_BC_STRING  = 8'd10;
  localparam logic [TYPE_W-1:0] TYPE_BC_NUMBER  = 8'd11;

  // Relay lengths in bytes
  localparam logic [RLEN_W-1:0] HEADER_BYTES = 9'd11;
  localparam logic [RLEN_W-1:0] STRING_EXTRA = 9'd1;
  localparam logic [RLEN_W-1:0] NUMBER_EXTRA = 9'd4;

  // Register reset values
  localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST   = 32'd0;
  localparam logic [KEEP_W-1:0] AGE_LIMIT_RST     = 16'd7000;
  localparam logic [DRAW_W-1:0] RELAY_PERCENT_RST = 7'd90;
  localparam logic [HOP_W-1:0]  MAX_HOPS_RST      = 8'd1;

  // Input action codes
  localparam logic ACTION_PACKET = 1'b0;
  localparam logic ACTION_SWEEP  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ADDRESS   = 2'd0,
    REG_AGE_LIMIT     = 2'd1,
    REG_RELAY_PERCENT = 2'd2,
    REG_MAX_HOPS      = 2'd3
  } reg_index_e;

  typedef enum logic [1:0] {
    OUTCOME_OWN   = 2'd0,
    OUTCOME_DUP   = 2'd1,
    OUTCOME_NEW   = 2'd2,
    OUTCOME_SWEEP = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    DELIVER_NONE   = 2'd0,
    DELIVER_STRING = 2'd1,
    DELIVER_NUMBER = 2'd2
  } deliver_e;

  // One node table entry as held in the table RAM
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [TIME_W-1:0] last_seen;
    logic [ID_W-1:0]   last_id;
    logic [WORD_W-1:0] status;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// File: src/frdt_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module frdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// File: src/flood_relay_dedup_table.sv
// Top level of the flood relay duplicate suppression table.
//
// Each input item is either a received packet header or an age sweep of the
// node table, and each gives exactly one result item. The table entries
// (address, last-seen time, last message id, status word) sit in one
// single-port RAM with a registered read; the valid bits and the member
// count are flip-flops and reset clears them at once, so the block takes
// items right after reset. The walk over the RAM visits each entry with an
// address step, then a compare step. A sweep walks the whole table; a packet
// from a known sender stops at its slot, an unknown sender walks the whole
// table and then fills the lowest free slot (no fill when the table is full),
// and a packet from this node's own address skips the walk. One item is
// worked on at a time; the next item can be taken in the cycle after the
// result is loaded, even while that result still waits in the output
// register. Configuration writes are registered and are meant for idle times only.
`default_nettype none
module flood_relay_dedup_table (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [frdt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [frdt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                action_i,
  input  wire logic [frdt_pkg::TYPE_W-1:0]         packet_type_i,
  input  wire logic [frdt_pkg::ID_W-1:0]           message_id_i,
  input  wire logic [frdt_pkg::ADDR_W-1:0]         source_address_i,
  input  wire logic [frdt_pkg::ADDR_W-1:0]         dest_address_i,
  input  wire logic [frdt_pkg::HOP_W-1:0]          hop_count_i,
  input  wire logic [frdt_pkg::WORD_W-1:0]         payload_word_i,
  input  wire logic [frdt_pkg::SLEN_W-1:0]         string_length_i,
  input  wire logic [frdt_pkg::TIME_W-1:0]         now_ms_i,
  input  wire logic [frdt_pkg::DRAW_W-1:0]         random_draw_i,
  // output channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [1:0]                               outcome_o,
  output logic [1:0]                               deliver_kind_o,
  output logic [frdt_pkg::WORD_W-1:0]              deliver_value_o,
  output logic                                     relay_o,
  output logic [frdt_pkg::HOP_W-1:0]               relay_hop_count_o,
  output logic [frdt_pkg::RLEN_W-1:0]              relay_length_o,
  output logic                                     table_full_o,
  output logic [frdt_pkg::MEMBER_W-1:0]            member_total_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_INS,
    ST_SWP_RD,
    ST_SWP_CMP,
    ST_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [frdt_pkg::ADDR_W-1:0] own_addr_q;
  logic [frdt_pkg::KEEP_W-1:0] keep_q;
  logic [frdt_pkg::DRAW_W-1:0] percent_q;
  logic [frdt_pkg::HOP_W-1:0]  max_hops_q;

  // latched input item
  logic                          sweep_q;
  logic [frdt_pkg::TYPE_W-1:0]   ptype_q;
  logic [frdt_pkg::ID_W-1:0]     msg_id_q;
  logic [frdt_pkg::ADDR_W-1:0]   src_q;
  logic [frdt_pkg::ADDR_W-1:0]   dst_q;
  logic [frdt_pkg::HOP_W-1:0]    hops_q;
  logic [frdt_pkg::WORD_W-1:0]   word_q;
  logic [frdt_pkg::SLEN_W-1:0]   slen_q;
  logic [frdt_pkg::TIME_W-1:0]   now_q;
  logic [frdt_pkg::DRAW_W-1:0]   draw_q;

  // walk and verdict state
  logic [frdt_pkg::IDX_W-1:0]         idx_q;
  logic                               free_found_q;
  logic [frdt_pkg::IDX_W-1:0]         free_idx_q;
  logic                               own_q;
  logic                               dup_q;
  logic                               full_q;
  logic [frdt_pkg::TABLE_ENTRIES-1:0] valid_q;
  logic [frdt_pkg::CNT_W-1:0]         total_q;

  // table RAM
  logic                         ram_we;
  logic [frdt_pkg::IDX_W-1:0]   ram_addr;
  frdt_pkg::entry_t             ram_wdata;
  frdt_pkg::entry_t             ram_rdata;

  logic                          last_idx;
  logic                          hit;
  logic                          newer;
  logic                          is_hb;
  logic [frdt_pkg::TIME_W-1:0]   expiry;
  logic                          expired;

  // result fields of the item in hand
  frdt_pkg::outcome_e            res_outcome;
  frdt_pkg::deliver_e            res_kind;
  logic [frdt_pkg::WORD_W-1:0]   res_value;
  logic                          res_relay;
  logic [frdt_pkg::HOP_W-1:0]    res_rhops;
  logic [frdt_pkg::RLEN_W-1:0]   res_rlen;
  logic                          candidate;
  logic [frdt_pkg::RLEN_W-1:0]   type_len;

  frdt_ram #(
    .WIDTH (frdt_pkg::ENTRY_W),
    .DEPTH (frdt_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);

  assign last_idx = (idx_q == frdt_pkg::IDX_W'(frdt_pkg::TABLE_ENTRIES - 1));
  assign hit      = valid_q[idx_q] && (ram_rdata.address == src_q);
  assign newer    = (msg_id_q > ram_rdata.last_id);
  assign is_hb    = (ptype_q == frdt_pkg::TYPE_HEARTBEAT);
  // 32-bit wrap on the expiry time, as the node timer does
  assign expiry   = ram_rdata.last_seen + frdt_pkg::TIME_W'(keep_q);
  assign expired  = valid_q[idx_q] && (expiry < now_q);

  // RAM port: refresh a matched entry in place on a newer id, or fill the free slot
  always_comb begin
    ram_addr  = (state_q == ST_INS) ? free_idx_q : idx_q;
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    if (state_q == ST_CMP && hit && newer) begin
      ram_we              = 1'b1;
      ram_wdata.last_id   = msg_id_q;
      ram_wdata.last_seen = now_q;
      if (is_hb) begin
        ram_wdata.status = word_q;
      end
    end else if (state_q == ST_INS) begin
      ram_we              = 1'b1;
      ram_wdata.address   = src_q;
      ram_wdata.last_seen = now_q;
      ram_wdata.last_id   = msg_id_q;
      ram_wdata.status    = is_hb ? word_q : '0;
    end
  end

  // Result of the item in hand: delivery, relay decision and length
  always_comb begin
    candidate = 1'b0;
    res_kind  = frdt_pkg::DELIVER_NONE;
    type_len  = '0;
    case (ptype_q)
      frdt_pkg::TYPE_HEARTBEAT: begin
        candidate = 1'b1;
        type_len  = frdt_pkg::HEADER_BYTES;
      end
      frdt_pkg::TYPE_UNI_STRING, frdt_pkg::TYPE_UNI_NUMBER: begin
        if (dst_q == own_addr_q) begin
          res_kind = (ptype_q == frdt_pkg::TYPE_UNI_STRING) ?
                     frdt_pkg::DELIVER_STRING : frdt_pkg::DELIVER_NUMBER;
        end else begin
          candidate = 1'b1;
        end
      end
      frdt_pkg::TYPE_BC_STRING, frdt_pkg::TYPE_BC_NUMBER: begin
        res_kind  = (ptype_q == frdt_pkg::TYPE_BC_STRING) ?
                    frdt_pkg::DELIVER_STRING : frdt_pkg::DELIVER_NUMBER;
        candidate = 1'b1;
      end
      default: begin
      end
    endcase
    if (ptype_q inside {frdt_pkg::TYPE_UNI_STRING, frdt_pkg::TYPE_BC_STRING}) begin
      type_len = frdt_pkg::HEADER_BYTES + frdt_pkg::STRING_EXTRA +
                 frdt_pkg::RLEN_W'(slen_q);
    end else if (ptype_q inside {frdt_pkg::TYPE_UNI_NUMBER, frdt_pkg::TYPE_BC_NUMBER}) begin
      type_len = frdt_pkg::HEADER_BYTES + frdt_pkg::NUMBER_EXTRA;
    end

    res_relay = candidate && (hops_q < max_hops_q) && (draw_q < percent_q);
    res_value = (res_kind == frdt_pkg::DELIVER_NUMBER) ? word_q : '0;
    res_rhops = res_relay ? hops_q + frdt_pkg::HOP_W'(1) : '0;
    res_rlen  = res_relay ? type_len : '0;

    if (sweep_q) begin
      res_outcome = frdt_pkg::OUTCOME_SWEEP;
    end else if (own_q) begin
      res_outcome = frdt_pkg::OUTCOME_OWN;
    end else if (dup_q) begin
      res_outcome = frdt_pkg::OUTCOME_DUP;
    end else begin
      res_outcome = frdt_pkg::OUTCOME_NEW;
    end
    // only a new packet carries delivery and relay fields
    if (res_outcome != frdt_pkg::OUTCOME_NEW) begin
      res_kind  = frdt_pkg::DELIVER_NONE;
      res_value = '0;
      res_relay = 1'b0;
      res_rhops = '0;
      res_rlen  = '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= frdt_pkg::OWN_ADDRESS_RST;
      keep_q     <= frdt_pkg::AGE_LIMIT_RST;
      percent_q  <= frdt_pkg::RELAY_PERCENT_RST;
      max_hops_q <= frdt_pkg::MAX_HOPS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        frdt_pkg::REG_OWN_ADDRESS:   own_addr_q <= cfg_data_i[frdt_pkg::ADDR_W-1:0];
        frdt_pkg::REG_AGE_LIMIT:     keep_q     <= cfg_data_i[frdt_pkg::KEEP_W-1:0];
        frdt_pkg::REG_RELAY_PERCENT: percent_q  <= cfg_data_i[frdt_pkg::DRAW_W-1:0];
        frdt_pkg::REG_MAX_HOPS:      max_hops_q <= cfg_data_i[frdt_pkg::HOP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input latch: payload registers, loaded on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      sweep_q  <= (action_i == frdt_pkg::ACTION_SWEEP);
      ptype_q  <= packet_type_i;
      msg_id_q <= message_id_i;
      src_q    <= source_address_i;
      dst_q    <= dest_address_i;
      hops_q   <= hop_count_i;
      word_q   <= payload_word_i;
      slen_q   <= string_length_i;
      now_q    <= now_ms_i;
      draw_q   <= random_draw_i;
    end
  end

  // Sequencer: walk the table, update it, and hand the result to the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      idx_q             <= '0;
      free_found_q      <= 1'b0;
      free_idx_q        <= '0;
      own_q             <= 1'b0;
      dup_q             <= 1'b0;
      full_q            <= 1'b0;
      valid_q           <= '0;
      total_q           <= '0;
      out_valid_o       <= 1'b0;
      outcome_o         <= '0;
      deliver_kind_o    <= '0;
      deliver_value_o   <= '0;
      relay_o           <= 1'b0;
      relay_hop_count_o <= '0;
      relay_length_o    <= '0;
      table_full_o      <= 1'b0;
      member_total_o    <= '0;
    end else begin
      // drop the result once taken, unless a new one is loaded in its place
      if (out_valid_o && !out_stall_i && state_q != ST_OUT) begin
        out_valid_o <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            idx_q        <= '0;
            free_found_q <= 1'b0;
            own_q        <= 1'b0;
            dup_q        <= 1'b0;
            full_q       <= 1'b0;
            if (action_i == frdt_pkg::ACTION_SWEEP) begin
              state_q <= ST_SWP_RD;
            end else if (source_address_i == own_addr_q) begin
              own_q   <= 1'b1;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_RD;
            end
          end
        end

        ST_RD: begin
          state_q <= ST_CMP;
        end

        ST_CMP: begin
          if (hit) begin
            dup_q   <= !newer;
            state_q <= ST_OUT;
          end else begin
            // remember the lowest free slot on the way
            if (!valid_q[idx_q] && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= idx_q;
            end
            if (last_idx) begin
              if (free_found_q || !valid_q[idx_q]) begin
                state_q <= ST_INS;
              end else begin
                full_q  <= 1'b1;
                state_q <= ST_OUT;
              end
            end else begin
              idx_q   <= idx_q + frdt_pkg::IDX_W'(1);
              state_q <= ST_RD;
            end
          end
        end

        ST_INS: begin
          valid_q[free_idx_q] <= 1'b1;
          total_q             <= total_q + frdt_pkg::CNT_W'(1);
          state_q             <= ST_OUT;
        end

        ST_SWP_RD: begin
          state_q <= ST_SWP_CMP;
        end

        ST_SWP_CMP: begin
          if (expired) begin
            valid_q[idx_q] <= 1'b0;
            total_q        <= total_q - frdt_pkg::CNT_W'(1);
          end
          if (last_idx) begin
            state_q <= ST_OUT;
          end else begin
            idx_q   <= idx_q + frdt_pkg::IDX_W'(1);
            state_q <= ST_SWP_RD;
          end
        end

        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o       <= 1'b1;
            outcome_o         <= res_outcome;
            deliver_kind_o    <= res_kind;
            deliver_value_o   <= res_value;
            relay_o           <= res_relay;
            relay_hop_count_o <= res_rhops;
            relay_length_o    <= res_rlen;
            table_full_o      <= full_q && !sweep_q && !own_q;
            member_total_o    <= frdt_pkg::MEMBER_W'(total_q);
            state_q           <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sim/flood_relay_dedup_table_test.sv
// Self-checking testbench of the flood relay duplicate table: directed and random items.
`default_nettype none
module flood_relay_dedup_table_test;
  import frdt_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 11;
  // Longest walk is an unknown sender (whole table, then insert), plus margin
  localparam int DRAIN_CYCLES   = 2 * TABLE_ENTRIES + 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int POOL_SIZE      = 20;
  localparam int PHASE_ITEMS    = 275;
  localparam int PHASES         = 5;
  localparam int MAX_REPORTS    = 10;

  localparam logic [ADDR_W-1:0] NODE_A = 32'h0000_0001;
  localparam logic [ADDR_W-1:0] NODE_B = 32'hFFFF_FFFF;
  localparam logic [ADDR_W-1:0] NODE_C = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] NODE_D = 32'h5555_AAAA;
  localparam logic [ADDR_W-1:0] NODE_E = 32'hAAAA_5555;
  localparam logic [ADDR_W-1:0] NODE_F = 32'h7FFF_FFFF;

  typedef struct packed {
    logic              action;
    logic [TYPE_W-1:0] ptype;
    logic [ID_W-1:0]   msg_id;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [HOP_W-1:0]  hops;
    logic [WORD_W-1:0] word;
    logic [SLEN_W-1:0] slen;
    logic [TIME_W-1:0] now;
    logic [DRAW_W-1:0] draw;
  } header_t;

  typedef struct packed {
    outcome_e            outcome;
    deliver_e            kind;
    logic [WORD_W-1:0]   value;
    logic                relay;
    logic [HOP_W-1:0]    relay_hops;
    logic [RLEN_W-1:0]   relay_len;
    logic                full;
    logic [MEMBER_W-1:0] members;
  } verdict_t;

  // Node table mirror: predicts one verdict per header and checks them in order.
  class dedup_board;
    logic [ADDR_W-1:0] own_address;
    logic [KEEP_W-1:0] age_limit;
    logic [DRAW_W-1:0] relay_percent;
    logic [HOP_W-1:0]  max_hops;
    bit                used [TABLE_ENTRIES];
    logic [ADDR_W-1:0] address [TABLE_ENTRIES];
    logic [TIME_W-1:0] last_seen [TABLE_ENTRIES];
    logic [ID_W-1:0]   last_id [TABLE_ENTRIES];
    logic [WORD_W-1:0] status [TABLE_ENTRIES];
    int                member_count;
    verdict_t          awaited[$];
    int                errors;

    function new();
      own_address   = OWN_ADDRESS_RST;
      age_limit     = AGE_LIMIT_RST;
      relay_percent = RELAY_PERCENT_RST;
      max_hops      = MAX_HOPS_RST;
      for (int i = 0; i < TABLE_ENTRIES; i++) used[i] = 1'b0;
      member_count = 0;
      errors       = 0;
    endfunction

    function void write_reg(reg_index_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_OWN_ADDRESS:   own_address   = data[ADDR_W-1:0];
        REG_AGE_LIMIT:     age_limit     = data[KEEP_W-1:0];
        REG_RELAY_PERCENT: relay_percent = data[DRAW_W-1:0];
        REG_MAX_HOPS:      max_hops      = data[HOP_W-1:0];
        default: ;
      endcase
    endfunction

    function verdict_t judge_header(header_t h);
      verdict_t          v;
      int                slot;
      bit                fresh;
      bit                candidate;
      logic [TIME_W-1:0] expiry;
      v         = '0;
      slot      = -1;
      fresh     = 1'b1;
      candidate = 1'b0;
      if (h.action == ACTION_SWEEP) begin
        // Expiry wraps at 32 bits before the compare
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          expiry = last_seen[i] + TIME_W'(age_limit);
          if (used[i] && expiry < h.now) begin
            used[i] = 1'b0;
            member_count--;
          end
        end
        v.outcome = OUTCOME_SWEEP;
      end else if (h.src == own_address) begin
        v.outcome = OUTCOME_OWN;
      end else begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot < 0 && used[i] && address[i] == h.src) slot = i;
        if (slot < 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot < 0 && !used[i]) slot = i;
          if (slot < 0) begin
            v.full = 1'b1;
          end else begin
            used[slot]      = 1'b1;
            address[slot]   = h.src;
            last_seen[slot] = h.now;
            last_id[slot]   = h.msg_id;
            status[slot]    = '0;
            member_count++;
          end
        end else if (h.msg_id > last_id[slot]) begin
          last_id[slot]   = h.msg_id;
          last_seen[slot] = h.now;
        end else begin
          fresh = 1'b0;
        end

        if (!fresh) begin
          v.outcome = OUTCOME_DUP;
        end else begin
          v.outcome = OUTCOME_NEW;
          case (h.ptype)
            TYPE_HEARTBEAT: begin
              // Status of a sender that found no free slot is dropped
              if (slot >= 0) status[slot] = h.word;
              candidate   = 1'b1;
              v.relay_len = HEADER_BYTES;
            end
            TYPE_UNI_STRING, TYPE_UNI_NUMBER: begin
              if (h.dst == own_address)
                v.kind = (h.ptype == TYPE_UNI_STRING) ? DELIVER_STRING : DELIVER_NUMBER;
              else
                candidate = 1'b1;
            end
            TYPE_BC_STRING, TYPE_BC_NUMBER: begin
              v.kind    = (h.ptype == TYPE_BC_STRING) ? DELIVER_STRING : DELIVER_NUMBER;
              candidate = 1'b1;
            end
            default: ;
          endcase
          if (v.kind == DELIVER_NUMBER) v.value = h.word;
          if (h.ptype == TYPE_UNI_STRING || h.ptype == TYPE_BC_STRING)
            v.relay_len = HEADER_BYTES + STRING_EXTRA + RLEN_W'(h.slen);
          else if (h.ptype == TYPE_UNI_NUMBER || h.ptype == TYPE_BC_NUMBER)
            v.relay_len = HEADER_BYTES + NUMBER_EXTRA;
          if (candidate && h.hops < max_hops && h.draw < relay_percent) begin
            v.relay      = 1'b1;
            v.relay_hops = h.hops + 8'd1;
          end
          if (!v.relay) v.relay_len = '0;
        end
      end
      v.members = MEMBER_W'(member_count);
      return v;
    endfunction

    function void note_header(header_t h);
      awaited.insert(awaited.size(), judge_header(h));
    endfunction

    function string show(verdict_t v);
      return $sformatf({"outcome=%0d kind=%0d value=%h relay=%b hops=%0d len=%0d",
                        " full=%b members=%0d"},
                       v.outcome, v.kind, v.value, v.relay, v.relay_hops, v.relay_len, v.full,
                       v.members);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected result: %s", show(got));
        return;
      end
      want = awaited.pop_front();
      if (got.outcome !== want.outcome || got.kind !== want.kind ||
          got.value !== want.value || got.relay !== want.relay ||
          got.relay_hops !== want.relay_hops || got.relay_len !== want.relay_len ||
          got.full !== want.full || got.members !== want.members) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch:\n  expected %s\n  actual   %s", show(want), show(got));
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  reg_index_e            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  header_t               drive;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            outcome;
  logic [1:0]            deliver_kind;
  logic [WORD_W-1:0]     deliver_value;
  logic                  relay;
  logic [HOP_W-1:0]      relay_hop_count;
  logic [RLEN_W-1:0]     relay_length;
  logic                  table_full;
  logic [MEMBER_W-1:0]   member_total;

  logic                  idle_on;
  logic                  hold_request;
  int                    quiet_cycles = 0;
  dedup_board            board;

  flood_relay_dedup_table i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .action_i          (drive.action),
    .packet_type_i     (drive.ptype),
    .message_id_i      (drive.msg_id),
    .source_address_i  (drive.src),
    .dest_address_i    (drive.dst),
    .hop_count_i       (drive.hops),
    .payload_word_i    (drive.word),
    .string_length_i   (drive.slen),
    .now_ms_i          (drive.now),
    .random_draw_i     (drive.draw),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .outcome_o         (outcome),
    .deliver_kind_o    (deliver_kind),
    .deliver_value_o   (deliver_value),
    .relay_o           (relay),
    .relay_hop_count_o (relay_hop_count),
    .relay_length_o    (relay_length),
    .table_full_o      (table_full),
    .member_total_o    (member_total)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  function automatic header_t pkt(logic act, logic [TYPE_W-1:0] ptype, logic [ID_W-1:0] id,
                                  logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                                  logic [HOP_W-1:0] hops, logic [WORD_W-1:0] word,
                                  logic [SLEN_W-1:0] slen, logic [TIME_W-1:0] now,
                                  logic [DRAW_W-1:0] draw);
    header_t h;
    h = '{act, ptype, id, src, dst, hops, word, slen, now, draw};
    return h;
  endfunction

  // Offer one item from a falling edge, hold it until accepted, then maybe pause.
  task automatic offer(header_t h);
    drive    = h;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_header(h);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // Leave the write enable high; the caller drops it after the last write.
  task automatic write_reg(reg_index_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    board.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Drain every awaited verdict, then let the walk of a silent item finish.
  task automatic settle();
    in_valid = 1'b0;
    while (board.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin : result_stall
    int burst;
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        held      = 1'b1;
        out_stall = 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        out_stall = 1'b1;
        burst     = $urandom_range(1, 13);
        repeat (burst) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.outcome    = outcome_e'(outcome);
      got.kind       = deliver_e'(deliver_kind);
      got.value      = deliver_value;
      got.relay      = relay;
      got.relay_hops = relay_hop_count;
      got.relay_len  = relay_length;
      got.full       = table_full;
      got.members    = member_total;
      board.check_verdict(got);
    end
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int                p;
    int                n;
    int                k;
    int                pick;
    header_t           h;
    logic [TIME_W-1:0] now_ms;
    logic [ADDR_W-1:0] pool_addr [POOL_SIZE];
    logic [ID_W-1:0]   pool_id [POOL_SIZE];
    logic [ADDR_W-1:0] set_own;
    logic [KEEP_W-1:0] set_keep;
    logic [DRAW_W-1:0] set_percent;
    logic [HOP_W-1:0]  set_hops;

    board        = new();
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_OWN_ADDRESS;
    cfg_data     = '0;
    in_valid     = 1'b0;
    drive        = '0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    now_ms       = 32'd1000;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed part under reset settings: own address 0, keep 7000, 90 %, one hop.
    // Own packet, then a new heartbeat that relays, then an equal and an older id.
    offer(pkt(ACTION_PACKET, TYPE_HEARTBEAT, 8'd1, 32'h0, 32'h0, 8'd0, 32'h1234_5678,
              8'd0, 32'd100, 7'd0));
    offer(pkt(ACTION_PACKET, TYPE_HEARTBEAT, 8'd5, NODE_A, 32'h0, 8'd0, 32'hCAFE_0001,
              8'd0, 32'd100, 7'd0));
    offer(pkt(ACTION_PACKET, TYPE_HEARTBEAT, 8'd5, NODE_A, 32'h0, 8'd0, 32'h0, 8'd0,
              32'd100, 7'd0));
    offer(pkt(ACTION_PACKET, TYPE_UNI_NUMBER, 8'd4, NODE_A, 32'h0, 8'd0, 32'h0, 8'd0,
              32'd100, 7'd0));
    // Unicast string to this node is delivered, foreign unicast number relayed
    offer(pkt(ACTION_PACKET, TYPE_UNI_STRING, 8'd6, NODE_A, 32'h0, 8'd0, 32'h0, 8'd255,
              32'd100, 7'd0));
    offer(pkt(ACTION_PACKET, TYPE_UNI_NUMBER, 8'd255, NODE_A, 32'hFFFF_FFFF, 8'd0,
              32'h0BAD_F00D, 8'd0, 32'd100, 7'd89));
    // Broadcast string: draw equal to the percentage blocks relay, one below relays
    offer(pkt(ACTION_PACKET, TYPE_BC_STRING, 8'd0, NODE_B, 32'h0, 8'd0, 32'h0, 8'd255,
              32'd100, 7'd90));
    offer(pkt(ACTION_PACKET, TYPE_BC_STRING, 8'd1, NODE_B, 32'h0, 8'd0, 32'h0, 8'd255,
              32'd100, 7'd89));
    // Broadcast number at the hop limit: delivered, not relayed
    offer(pkt(ACTION_PACKET, TYPE_BC_NUMBER, 8'd9, NODE_C, 32'h0, 8'd1, 32'hFFFF_FFFF,
              8'd0, 32'd100, 7'd0));
    // Unknown types still update the table
    offer(pkt(ACTION_PACKET, 8'd0, 8'd3, NODE_D, 32'h0, 8'd0, 32'h0, 8'd0, 32'd100, 7'd0));
    offer(pkt(ACTION_PACKET, 8'd255, 8'd3, NODE_E, 32'h0, 8'd0, 32'h0, 8'd0, 32'd100, 7'd0));
    // Sweep exactly at the keep boundary drops nothing
    offer(pkt(ACTION_SWEEP, 8'd0, 8'd0, 32'h0, 32'h0, 8'd0, 32'h0, 8'd0, 32'd7100, 7'd0));
    // Fill the table, then one more sender finds it full
    for (k = 0; k < TABLE_ENTRIES - 5; k++)
      offer(pkt(ACTION_PACKET, TYPE_HEARTBEAT, 8'd0, 32'h100 + 32'(k), 32'h0, 8'd0,
                32'(k), 8'd0, 32'd200, 7'd0));
    offer(pkt(ACTION_PACKET, TYPE_HEARTBEAT, 8'd7, NODE_F, 32'h0, 8'd255, 32'hFFFF_FFFF,
              8'd0, 32'd200, 7'd127));
    // Partial sweep, then a sweep at the top of time empties the table
    offer(pkt(ACTION_SWEEP, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
              32'hFFFF_FFFF, 8'hFF, 32'd7150, 7'h7F));
    offer(pkt(ACTION_SWEEP, 8'd0, 8'd0, 32'h0, 32'h0, 8'd0, 32'h0, 8'd0, 32'hFFFF_FFFF,
              7'd0));
    settle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          set_own = $urandom; set_keep = 16'd0; set_percent = 7'd0; set_hops = 8'd0;
        end
        1: begin
          set_own = 32'hFFFF_FFFF; set_keep = 16'hFFFF; set_percent = 7'd100;
          set_hops = 8'd255;
        end
        2: begin
          set_own = $urandom; set_keep = 16'd300; set_percent = 7'd127; set_hops = 8'd3;
        end
        3: begin
          // Start just below the time wrap
          set_own = 32'h0; set_keep = 16'd2000; set_percent = 7'd50; set_hops = 8'd1;
          now_ms  = 32'hFFFF_F000;
        end
        default: begin
          set_own = $urandom; set_keep = 16'd7000; set_percent = 7'd90; set_hops = 8'd2;
          idle_on = 1'b0;
        end
      endcase
      write_reg(REG_OWN_ADDRESS, set_own);
      write_reg(REG_AGE_LIMIT, CFG_DATA_W'(set_keep));
      write_reg(REG_RELAY_PERCENT, CFG_DATA_W'(set_percent));
      write_reg(REG_MAX_HOPS, CFG_DATA_W'(set_hops));
      cfg_we = 1'b0;

      // More senders than slots, so the table fills when the keep time is long
      for (k = 0; k < POOL_SIZE; k++) begin
        pool_addr[k] = $urandom;
        pool_id[k]   = ID_W'($urandom_range(0, 15));
      end
      // Hold the receiver off while the sender keeps offering
      if (p == 2) hold_request = 1'b1;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        now_ms = now_ms + TIME_W'($urandom_range(0, 60));
        if ($urandom_range(0, 39) == 0) now_ms = now_ms + TIME_W'($urandom_range(1000, 100000));
        h     = '0;
        h.now = now_ms;
        if ($urandom_range(0, 9) == 0) begin
          // Sweep with noise on the unused fields
          h.action = ACTION_SWEEP;
          h.ptype  = TYPE_W'($urandom);
          h.msg_id = ID_W'($urandom);
          h.src    = $urandom;
          h.dst    = $urandom;
          h.hops   = HOP_W'($urandom);
          h.word   = $urandom;
          h.slen   = SLEN_W'($urandom);
          h.draw   = DRAW_W'($urandom);
        end else begin
          h.action = ACTION_PACKET;
          k        = $urandom_range(0, POOL_SIZE - 1);
          pick     = $urandom_range(0, 31);
          if (pick == 0)
            h.src = board.own_address;
          else if (pick == 1)
            h.src = $urandom;
          else
            h.src = pool_addr[k];
          // Mostly rising ids per sender; some repeats and stray ids
          pick = $urandom_range(0, 9);
          if (pick < 7) begin
            pool_id[k] = pool_id[k] + ID_W'($urandom_range(1, 3));
            h.msg_id   = pool_id[k];
          end else if (pick < 9) begin
            h.msg_id = pool_id[k];
          end else begin
            h.msg_id = ID_W'($urandom);
          end
          if ($urandom_range(0, 4) == 0)
            h.ptype = TYPE_W'($urandom);
          else
            h.ptype = TYPE_HEARTBEAT + TYPE_W'($urandom_range(0, 4));
          if ($urandom_range(0, 1) == 0)
            h.dst = board.own_address;
          else
            h.dst = $urandom;
          if ($urandom_range(0, 9) < 7)
            h.hops = HOP_W'($urandom_range(0, 4));
          else
            h.hops = HOP_W'($urandom);
          h.word = $urandom;
          h.slen = SLEN_W'($urandom);
          if ($urandom_range(0, 6) == 0)
            h.draw = DRAW_W'($urandom);
          else
            h.draw = DRAW_W'($urandom_range(0, 99));
        end
        offer(h);
      end
      settle();
    end

    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
